FILE: hdl/date_ordered_ledger_table_top_assert.svh
// Assertion macros shared by the ledger table modules.
`ifndef DATE_ORDERED_LEDGER_TABLE_TOP_ASSERT_SVH
`define DATE_ORDERED_LEDGER_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define DOLT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ledger table assertion failed");

// Next-cycle implication, sampled on clk, quiet during rst.
`define DOLT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ledger table assertion failed");

`endif

FILE: hdl/dolt_pkg.sv
// Shared types, widths and codes of the date-ordered ledger table.
package dolt_pkg;

  localparam int DEPTH_DEF = 32;

  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int AMOUNT_W = 30;
  localparam int INDEX_W  = 6;
  localparam int OPEN_W   = 32;
  localparam int BAL_W    = 40;
  localparam int STATUS_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ROW    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic                credit;
    logic [AMOUNT_W-1:0] amount;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                rd_prev;
    logic                shift_down;
    logic                put_new;
    logic                rd_next;
    logic                shift_up;
    logic                dec_cnt;
    logic                emit_init;
    logic                emit_rd;
    logic                single;
    logic [STATUS_W-1:0] single_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_remove;
    logic full;
    logic bad_idx;
    logic ptr_zero;
    logic rem_end;
    logic after;
    logic cnt_one;
    logic emit_end;
  } sts_t;

endpackage

FILE: hdl/dolt_ctrl.sv
// Sequencing state machine of the ledger table.
`include "date_ordered_ledger_table_top_assert.svh"

module dolt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  dolt_pkg::sts_t sts,
  output dolt_pkg::cmd_t cmd
);
  import dolt_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_CHECK     = 10'b0000000010,
    S_INS_RD    = 10'b0000000100,
    S_INS_CMP   = 10'b0000001000,
    S_INS_PUT   = 10'b0000010000,
    S_REM_RD    = 10'b0000100000,
    S_REM_WR    = 10'b0001000000,
    S_REM_DONE  = 10'b0010000000,
    S_EMIT_INIT = 10'b0100000000,
    S_EMIT      = 10'b1000000000
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.is_remove && sts.full) begin
          cmd.single = 1'b1;
          cmd.single_status = ST_FULL;
          state_next = S_IDLE;
        end else if (sts.is_remove && sts.bad_idx) begin
          cmd.single = 1'b1;
          cmd.single_status = ST_BADIDX;
          state_next = S_IDLE;
        end else if (sts.is_remove) begin
          state_next = S_REM_RD;
        end else begin
          state_next = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (sts.ptr_zero) begin
          state_next = S_INS_PUT;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts.after) begin
          cmd.shift_down = 1'b1;
          state_next = S_INS_RD;
        end else begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        cmd.put_new = 1'b1;
        state_next = S_EMIT_INIT;
      end
      S_REM_RD: begin
        if (sts.rem_end) begin
          state_next = S_REM_DONE;
        end else begin
          cmd.rd_next = 1'b1;
          state_next = S_REM_WR;
        end
      end
      S_REM_WR: begin
        cmd.shift_up = 1'b1;
        state_next = S_REM_RD;
      end
      S_REM_DONE: begin
        cmd.dec_cnt = 1'b1;
        if (sts.cnt_one) begin
          cmd.single = 1'b1;
          cmd.single_status = ST_EMPTY;
          state_next = S_IDLE;
        end else begin
          state_next = S_EMIT_INIT;
        end
      end
      S_EMIT_INIT: begin
        cmd.emit_init = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.emit_end) begin
          state_next = S_IDLE;
        end else begin
          cmd.emit_rd = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `DOLT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `DOLT_ASSERT_IMP(a_one_mem_cmd, busy, $onehot0({cmd.rd_prev, cmd.rd_next, cmd.emit_rd}))
  `DOLT_ASSERT_IMP(a_idle_quiet, !busy, !(cmd.put_new || cmd.shift_down || cmd.shift_up))

endmodule

FILE: hdl/dolt_dpath.sv
// Entry memory, pointers, balance accumulator and result register.
`include "date_ordered_ledger_table_top_assert.svh"

module dolt_dpath #(
  parameter int DEPTH = dolt_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dolt_pkg::cmd_t                       cmd,
  output dolt_pkg::sts_t                       sts,
  input  logic                                 cfg_we,
  input  logic [dolt_pkg::OPEN_W-1:0]          cfg_data,
  input  logic                                 opcode,
  input  logic [dolt_pkg::YEAR_W-1:0]          entry_year,
  input  logic [dolt_pkg::MONTH_W-1:0]         entry_month,
  input  logic [dolt_pkg::DAY_W-1:0]           entry_day,
  input  logic                                 is_credit,
  input  logic [dolt_pkg::AMOUNT_W-1:0]        amount,
  input  logic [dolt_pkg::INDEX_W-1:0]         remove_index,
  output logic                                 result_valid,
  output logic [dolt_pkg::STATUS_W-1:0]        status,
  output logic [dolt_pkg::INDEX_W-1:0]         position,
  output logic [dolt_pkg::YEAR_W-1:0]          row_year,
  output logic [dolt_pkg::MONTH_W-1:0]         row_month,
  output logic [dolt_pkg::DAY_W-1:0]           row_day,
  output logic                                 row_is_credit,
  output logic [dolt_pkg::AMOUNT_W-1:0]        row_amount,
  output logic signed [dolt_pkg::BAL_W-1:0]    running_balance,
  output logic                                 last
);
  import dolt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t mem [DEPTH];
  entry_t rdata;
  entry_t nr;
  entry_t wdata;

  logic                      op;
  logic [INDEX_W-1:0]        idx;
  logic [CW-1:0]             cnt;
  logic [CW-1:0]             ptr;
  logic [CW-1:0]             ptr_dec;
  logic [CW-1:0]             ptr_inc;
  logic                      rvalid;
  logic [IW-1:0]             rpos;
  logic signed [OPEN_W-1:0]  opening;
  logic signed [BAL_W-1:0]   bal;
  logic signed [BAL_W-1:0]   bal_next;
  logic                      wr_en;
  logic                      rd_en;
  logic [IW-1:0]             rd_addr;
  logic [IW-1:0]             wr_addr;

  assign ptr_dec = ptr - CW'(1);
  assign ptr_inc = ptr + CW'(1);

  assign wr_en   = cmd.shift_down || cmd.put_new || cmd.shift_up;
  assign wr_addr = ptr[IW-1:0];
  assign wdata   = cmd.put_new ? nr : rdata;
  assign rd_en   = cmd.rd_prev || cmd.rd_next || cmd.emit_rd;

  always_comb begin
    if (cmd.rd_prev) begin
      rd_addr = ptr_dec[IW-1:0];
    end else if (cmd.rd_next) begin
      rd_addr = ptr_inc[IW-1:0];
    end else begin
      rd_addr = ptr[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Status back to the controller.
  always_comb begin
    sts.is_remove = (op == OP_REMOVE);
    sts.full      = (cnt == CW'(DEPTH));
    sts.bad_idx   = (8'(idx) >= 8'(cnt));
    sts.ptr_zero  = (ptr == '0);
    sts.rem_end   = (ptr_inc >= cnt);
    sts.after     = ({rdata.year, rdata.month, rdata.day} > {nr.year, nr.month, nr.day});
    sts.cnt_one   = (cnt == CW'(1));
    sts.emit_end  = (ptr == cnt);
  end

  // Item latch and pointer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= opcode;
      idx       <= remove_index;
      nr.year   <= entry_year;
      nr.month  <= entry_month;
      nr.day    <= entry_day;
      nr.credit <= is_credit;
      nr.amount <= amount;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ptr <= (opcode == OP_REMOVE) ? CW'(remove_index) : cnt;
    end else if (cmd.shift_down) begin
      ptr <= ptr_dec;
    end else if (cmd.shift_up || cmd.emit_rd) begin
      ptr <= ptr_inc;
    end else if (cmd.emit_init) begin
      ptr <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.put_new) begin
      cnt <= cnt + CW'(1);
    end else if (cmd.dec_cnt) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      opening <= '0;
    end else if (cfg_we) begin
      opening <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else begin
      rvalid <= cmd.emit_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_rd) begin
      rpos <= ptr[IW-1:0];
    end
  end

  always_comb begin
    if (rdata.credit) begin
      bal_next = bal + $signed({{(BAL_W - AMOUNT_W){1'b0}}, rdata.amount});
    end else begin
      bal_next = bal - $signed({{(BAL_W - AMOUNT_W){1'b0}}, rdata.amount});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      bal <= BAL_W'(opening);
    end else if (rvalid) begin
      bal <= bal_next;
    end
  end

  // Result register, loaded with each table row or status row.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= rvalid || cmd.single;
    end
  end

  always_ff @(posedge clk) begin
    if (rvalid) begin
      status          <= ST_ROW;
      position        <= INDEX_W'(rpos);
      row_year        <= rdata.year;
      row_month       <= rdata.month;
      row_day         <= rdata.day;
      row_is_credit   <= rdata.credit;
      row_amount      <= rdata.amount;
      running_balance <= bal_next;
      last            <= ((CW'(rpos) + CW'(1)) == cnt);
    end else if (cmd.single) begin
      status          <= cmd.single_status;
      position        <= '0;
      row_year        <= '0;
      row_month       <= '0;
      row_day         <= '0;
      row_is_credit   <= 1'b0;
      row_amount      <= '0;
      running_balance <= BAL_W'(opening);
      last            <= 1'b1;
    end
  end

  `DOLT_ASSERT_IMP(a_cnt_range, 1'b1, cnt <= CW'(DEPTH))
  `DOLT_ASSERT_IMP(a_wr_in_range, wr_en, ptr < CW'(DEPTH))
  `DOLT_ASSERT_NXT(a_gap_after_last, result_valid && last, !result_valid)

endmodule

FILE: hdl/date_ordered_ledger_table_top.sv
// Top level of the date-ordered ledger table with running balance.
//
// Keeps up to DEPTH ledger entries sorted by year, month and day (stable:
// a new entry lands after stored entries of the same date). An item is
// taken when start is high and busy is low; opcode selects insert or
// remove-by-position. After every item the block streams the whole table,
// one row per clock with result_valid high for that single cycle, each row
// carrying its running balance from opening_balance; last marks the final
// row. The receiver cannot stall, so take every row in the cycle it shows.
// A full table, a bad remove index or a table emptied by a remove gives one
// status row instead. Work runs on the single-port entry memory: an insert
// moves each later-dated entry down a slot before it writes the new one, a
// remove moves each entry above the index up a slot, and busy stays high
// until the last row is read out. Rows follow one per cycle, and the final
// row, like a status row, shows as busy falls. Write opening_balance on the
// cfg channel only while idle; cfg_ready is always high.
module date_ordered_ledger_table_top #(
  parameter int DEPTH = dolt_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 opcode,
  input  logic [dolt_pkg::YEAR_W-1:0]          entry_year,
  input  logic [dolt_pkg::MONTH_W-1:0]         entry_month,
  input  logic [dolt_pkg::DAY_W-1:0]           entry_day,
  input  logic                                 is_credit,
  input  logic [dolt_pkg::AMOUNT_W-1:0]        amount,
  input  logic [dolt_pkg::INDEX_W-1:0]         remove_index,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dolt_pkg::OPEN_W-1:0]          cfg_data,
  output logic                                 result_valid,
  output logic [dolt_pkg::STATUS_W-1:0]        status,
  output logic [dolt_pkg::INDEX_W-1:0]         position,
  output logic [dolt_pkg::YEAR_W-1:0]          row_year,
  output logic [dolt_pkg::MONTH_W-1:0]         row_month,
  output logic [dolt_pkg::DAY_W-1:0]           row_day,
  output logic                                 row_is_credit,
  output logic [dolt_pkg::AMOUNT_W-1:0]        row_amount,
  output logic signed [dolt_pkg::BAL_W-1:0]    running_balance,
  output logic                                 last
);
  import dolt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The opening balance register is always free to take a write.
  assign cfg_ready = 1'b1;

  dolt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  dolt_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .opcode          (opcode),
    .entry_year      (entry_year),
    .entry_month     (entry_month),
    .entry_day       (entry_day),
    .is_credit       (is_credit),
    .amount          (amount),
    .remove_index    (remove_index),
    .result_valid    (result_valid),
    .status          (status),
    .position        (position),
    .row_year        (row_year),
    .row_month       (row_month),
    .row_day         (row_day),
    .row_is_credit   (row_is_credit),
    .row_amount      (row_amount),
    .running_balance (running_balance),
    .last            (last)
  );

endmodule

FILE: bench/ledger_stream_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the ledger row stream and compares every row the block emits.
module ledger_stream_checker #(
  parameter int DEPTH = dolt_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              opcode,
  input  logic [dolt_pkg::YEAR_W-1:0]       entry_year,
  input  logic [dolt_pkg::MONTH_W-1:0]      entry_month,
  input  logic [dolt_pkg::DAY_W-1:0]        entry_day,
  input  logic                              is_credit,
  input  logic [dolt_pkg::AMOUNT_W-1:0]     amount,
  input  logic [dolt_pkg::INDEX_W-1:0]      remove_index,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [dolt_pkg::OPEN_W-1:0]       cfg_data,
  input  logic                              result_valid,
  input  logic [dolt_pkg::STATUS_W-1:0]     status,
  input  logic [dolt_pkg::INDEX_W-1:0]      position,
  input  logic [dolt_pkg::YEAR_W-1:0]       row_year,
  input  logic [dolt_pkg::MONTH_W-1:0]      row_month,
  input  logic [dolt_pkg::DAY_W-1:0]        row_day,
  input  logic                              row_is_credit,
  input  logic [dolt_pkg::AMOUNT_W-1:0]     row_amount,
  input  logic signed [dolt_pkg::BAL_W-1:0] running_balance,
  input  logic                              last,
  output int                                error_count,
  output int                                rows_pending,
  output int                                rows_checked,
  output int                                full_seen,
  output int                                badidx_seen,
  output int                                empty_seen
);
  import dolt_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  position;
    entry_t              entry;
    logic [BAL_W-1:0]    balance;
    logic                last;
  } ledger_row_t;

  entry_t             ledger_q [DEPTH];
  int                 fill_q;
  logic [OPEN_W-1:0]  opening_q;
  ledger_row_t        expected_rows [$];
  ledger_row_t        want;

  function automatic ledger_row_t status_row(input logic [STATUS_W-1:0] st,
                                             input logic [BAL_W-1:0] bal);
    ledger_row_t r;
    r = '0;
    r.status  = st;
    r.balance = bal;
    r.last    = 1'b1;
    return r;
  endfunction

  // Apply one accepted operation to the shadow ledger and queue its rows.
  task automatic apply_ledger_op(input logic op, input entry_t item,
                                 input logic [INDEX_W-1:0] idx);
    logic [BAL_W-1:0] bal;
    ledger_row_t      r;
    int               pos;
    bal = {{(BAL_W-OPEN_W){opening_q[OPEN_W-1]}}, opening_q};
    if (op == OP_INSERT) begin
      if (fill_q >= DEPTH) begin
        expected_rows.push_back(status_row(ST_FULL, bal));
        return;
      end
      // stable order: slide only entries whose date is strictly later
      pos = fill_q;
      while (pos > 0 && {ledger_q[pos-1].year, ledger_q[pos-1].month, ledger_q[pos-1].day}
                        > {item.year, item.month, item.day}) begin
        ledger_q[pos] = ledger_q[pos-1];
        pos--;
      end
      ledger_q[pos] = item;
      fill_q++;
    end else begin
      if (int'(idx) >= fill_q) begin
        expected_rows.push_back(status_row(ST_BADIDX, bal));
        return;
      end
      for (int i = int'(idx); i + 1 < fill_q; i++) ledger_q[i] = ledger_q[i+1];
      fill_q--;
      if (fill_q == 0) begin
        expected_rows.push_back(status_row(ST_EMPTY, bal));
        return;
      end
    end
    for (int i = 0; i < fill_q; i++) begin
      if (ledger_q[i].credit) bal = bal + BAL_W'(ledger_q[i].amount);
      else bal = bal - BAL_W'(ledger_q[i].amount);
      r.status   = ST_ROW;
      r.position = INDEX_W'(i);
      r.entry    = ledger_q[i];
      r.balance  = bal;
      r.last     = (i + 1 == fill_q);
      expected_rows.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill_q    = 0;
      opening_q = '0;
      expected_rows.delete();
    end else begin
      if (result_valid === 1'b1) begin
        if (expected_rows.size() == 0) begin
          $display("%0t: row with nothing expected, status %0h position %0h",
                   $time, status, position);
          error_count++;
        end else begin
          want = expected_rows.pop_front();
          check_field("status", 64'(want.status), 64'(status));
          check_field("position", 64'(want.position), 64'(position));
          check_field("row_year", 64'(want.entry.year), 64'(row_year));
          check_field("row_month", 64'(want.entry.month), 64'(row_month));
          check_field("row_day", 64'(want.entry.day), 64'(row_day));
          check_field("row_is_credit", 64'(want.entry.credit), 64'(row_is_credit));
          check_field("row_amount", 64'(want.entry.amount), 64'(row_amount));
          check_field("running_balance", 64'(want.balance), 64'(unsigned'(running_balance)));
          check_field("last", 64'(want.last), 64'(last));
          rows_checked++;
          case (want.status)
            ST_FULL:   full_seen++;
            ST_BADIDX: badidx_seen++;
            ST_EMPTY:  empty_seen++;
            default: ;
          endcase
        end
      end
      if (cfg_valid && cfg_ready) opening_q = cfg_data;
      if (start && !busy)
        apply_ledger_op(opcode, '{entry_year, entry_month, entry_day, is_credit, amount},
                        remove_index);
    end
    rows_pending = expected_rows.size();
  end

endmodule

FILE: bench/date_ordered_ledger_table_top_tb.sv
`timescale 1ns / 100ps
// Testbench top: drives ledger operations and opening balances, and gives the verdict.
module date_ordered_ledger_table_top_tb;
  import dolt_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT = 2000;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       opcode;
  logic [YEAR_W-1:0]          entry_year;
  logic [MONTH_W-1:0]         entry_month;
  logic [DAY_W-1:0]           entry_day;
  logic                       is_credit;
  logic [AMOUNT_W-1:0]        amount;
  logic [INDEX_W-1:0]         remove_index;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [OPEN_W-1:0]          cfg_data;
  logic                       result_valid;
  logic [STATUS_W-1:0]        status;
  logic [INDEX_W-1:0]         position;
  logic [YEAR_W-1:0]          row_year;
  logic [MONTH_W-1:0]         row_month;
  logic [DAY_W-1:0]           row_day;
  logic                       row_is_credit;
  logic [AMOUNT_W-1:0]        row_amount;
  logic signed [BAL_W-1:0]    running_balance;
  logic                       last;

  int error_count;
  int rows_pending;
  int rows_checked;
  int full_seen;
  int badidx_seen;
  int empty_seen;

  // stimulus-side bookkeeping: a rough entry count to aim remove indices
  int stored_entries;
  int items_sent;
  int inserts_sent;
  int removes_sent;
  int balances_written;
  int quiet_cycles;

  date_ordered_ledger_table_top #(.DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .entry_year(entry_year), .entry_month(entry_month),
    .entry_day(entry_day), .is_credit(is_credit), .amount(amount),
    .remove_index(remove_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .status(status), .position(position),
    .row_year(row_year), .row_month(row_month), .row_day(row_day),
    .row_is_credit(row_is_credit), .row_amount(row_amount),
    .running_balance(running_balance), .last(last)
  );

  ledger_stream_checker #(.DEPTH(DEPTH)) i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .entry_year(entry_year), .entry_month(entry_month),
    .entry_day(entry_day), .is_credit(is_credit), .amount(amount),
    .remove_index(remove_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .status(status), .position(position),
    .row_year(row_year), .row_month(row_month), .row_day(row_day),
    .row_is_credit(row_is_credit), .row_amount(row_amount),
    .running_balance(running_balance), .last(last),
    .error_count(error_count), .rows_pending(rows_pending),
    .rows_checked(rows_checked), .full_seen(full_seen),
    .badidx_seen(badidx_seen), .empty_seen(empty_seen)
  );

  always #2 clk = ~clk;

  // Watchdog: count cycles in which no item, register write or row moves.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("date_ordered_ledger_table_top_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item at a falling edge and hold it until the block takes it.
  // Leave start high on return, so a following item can go out back to back.
  task automatic send_item(input logic op, input logic [YEAR_W-1:0] y,
                           input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d,
                           input logic c, input logic [AMOUNT_W-1:0] a,
                           input logic [INDEX_W-1:0] idx);
    start        = 1'b1;
    opcode       = op;
    entry_year   = y;
    entry_month  = m;
    entry_day    = d;
    is_credit    = c;
    amount       = a;
    remove_index = idx;
    // busy only moves on a rising edge, so its value here holds at the next one
    while (busy !== 1'b0) @(negedge clk);
    @(negedge clk);
    items_sent++;
    if (op == OP_INSERT) begin
      inserts_sent++;
      if (stored_entries < DEPTH) stored_entries++;
    end else begin
      removes_sent++;
      if (int'(idx) < stored_entries) stored_entries--;
    end
  endtask

  // Offer a remove; the date, flag and amount fields carry random filler.
  task automatic send_remove(input logic [INDEX_W-1:0] idx);
    send_item(OP_REMOVE, YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom),
              1'($urandom), AMOUNT_W'($urandom), idx);
  endtask

  // Drop start and hold off until every expected row is out and the block is idle.
  task automatic drain_rows();
    start = 1'b0;
    while (rows_pending != 0 || busy !== 1'b0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write the opening balance while the block is idle.
  task automatic write_opening(input logic [OPEN_W-1:0] value);
    drain_rows();
    cfg_valid = 1'b1;
    cfg_data  = value;
    while (cfg_ready !== 1'b1) @(negedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = $urandom;
    balances_written++;
  endtask

  // Random operations: insert_pct steers the table towards full or empty,
  // idle_pct is the per-cycle chance that the sender stays quiet after an item.
  task automatic run_phase(input int n_items, input int idle_pct, input int insert_pct);
    logic [YEAR_W-1:0]   y;
    logic [MONTH_W-1:0]  m;
    logic [DAY_W-1:0]    d;
    logic [AMOUNT_W-1:0] a;
    logic [INDEX_W-1:0]  idx;
    logic                op;
    int                  pick;
    int                  gap;
    y = 12'd2000;
    m = 4'd1;
    d = 5'd1;
    for (int n = 0; n < n_items; n++) begin
      op   = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      pick = $urandom_range(99);
      // reuse the previous date now and then to exercise equal-date ordering
      if (pick >= 25 && pick < 85) begin
        y = YEAR_W'(2000 + $urandom_range(3));
        m = MONTH_W'($urandom_range(12, 1));
        d = DAY_W'($urandom_range(28, 1));
      end else if (pick >= 85) begin
        y = YEAR_W'($urandom);
        m = MONTH_W'($urandom);
        d = DAY_W'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 70) a = AMOUNT_W'($urandom);
      else if (pick < 85) a = AMOUNT_W'($urandom_range(1000));
      else a = $urandom_range(1) ? '1 : '0;
      if (op == OP_REMOVE && stored_entries > 0 && $urandom_range(99) < 88)
        idx = INDEX_W'($urandom_range(stored_entries - 1));
      else
        idx = INDEX_W'($urandom_range(63));
      send_item(op, y, m, d, 1'($urandom_range(1)), a, idx);
      gap = 0;
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
      // an occasional long pause lands a gap anywhere in the block's work
      if (idle_pct > 0 && $urandom_range(99) < 5) gap += $urandom_range(150, 1);
      if (gap > 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    start        = 1'b0;
    opcode       = OP_INSERT;
    entry_year   = '0;
    entry_month  = '0;
    entry_day    = '0;
    is_credit    = 1'b0;
    amount       = '0;
    remove_index = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    stored_entries   = 0;
    items_sent       = 0;
    inserts_sent     = 0;
    removes_sent     = 0;
    balances_written = 0;
    repeat (9) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed part, opening balance still at its reset value of zero.
    // Remove from an empty table: bad index at both ends of the field.
    send_remove('0);
    send_remove('1);
    // Extreme dates and amounts, then equal and earlier dates around them.
    send_item(OP_INSERT, 12'd2001, 4'd6, 5'd15, 1'b0, 30'd500, INDEX_W'($urandom));
    send_item(OP_INSERT, '1, '1, '1, 1'b1, '1, INDEX_W'($urandom));
    send_item(OP_INSERT, '0, '0, '0, 1'b1, '0, INDEX_W'($urandom));
    send_item(OP_INSERT, 12'd2001, 4'd6, 5'd15, 1'b1, 30'd7, INDEX_W'($urandom));
    send_item(OP_INSERT, 12'd2001, 4'd6, 5'd14, 1'b0, '1, INDEX_W'($urandom));
    send_item(OP_INSERT, 12'd2001, 4'd5, 5'd31, 1'b1, 30'd1, INDEX_W'($urandom));
    // Index equal to the entry count is just out of range.
    send_remove(6'd6);
    // Remove the last, the first and a middle entry.
    send_remove(6'd5);
    send_remove(6'd0);
    send_remove(6'd2);
    write_opening('1);
    send_item(OP_INSERT, 12'd2001, 4'd6, 5'd15, 1'b0, '1, INDEX_W'($urandom));
    // Empty the table from the front; the removal that empties it reports it empty, and one more hits a bad index.
    while (stored_entries > 0)
      send_remove(6'd0);
    send_remove(6'd0);

    // Random part: fill towards full, churn, drain towards empty, refill.
    write_opening(32'h7FFF_FFFF);
    run_phase(53, 0, 80);
    write_opening(32'h8000_0000);
    run_phase(53, 45, 50);
    write_opening($urandom);
    run_phase(53, 15, 25);
    write_opening('0);
    run_phase(53, 0, 65);

    // Let the last stream finish, then allow a little slack for stray rows.
    start = 1'b0;
    while (rows_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("covered %0d items (%0d inserts, %0d removes) under %0d opening balances",
             items_sent, inserts_sent, removes_sent, balances_written);
    $display("checked %0d rows: %0d table full, %0d bad index, %0d table emptied",
             rows_checked, full_seen, badidx_seen, empty_seen);
    if (error_count == 0 && rows_pending == 0) begin
      $display("date_ordered_ledger_table_top_tb: done, clean");
    end else begin
      $display("date_ordered_ledger_table_top_tb: done, errors");
    end
    $finish;
  end

endmodule
